// ===== design/qsl_pkg.sv =====
// Shared types and constants for the quoted string literal lexer.
package qsl_pkg;

  // Lexer phases
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_BODY = 3'd1,
    PH_ESC  = 3'd2,
    PH_OCT  = 3'd3,
    PH_CSVQ = 3'd4
  } phase_t;

  // Result kinds
  localparam logic [2:0] KIND_BYTE       = 3'd0;
  localparam logic [2:0] KIND_STR_DONE   = 3'd1;
  localparam logic [2:0] KIND_CHAR_DONE  = 3'd2;
  localparam logic [2:0] KIND_NOT_LIT    = 3'd3;
  localparam logic [2:0] KIND_UNTERM     = 3'd4;
  localparam logic [2:0] KIND_TOO_LONG   = 3'd5;
  localparam logic [2:0] KIND_CHAR_LONG  = 3'd6;

  // Configuration register indexes
  localparam logic [2:0] CFG_DELIM_A    = 3'd0;
  localparam logic [2:0] CFG_DELIM_B    = 3'd1;
  localparam logic [2:0] CFG_CHAR_DELIM = 3'd2;
  localparam logic [2:0] CFG_CSV_MODE   = 3'd3;
  localparam logic [2:0] CFG_MAX_LEN    = 3'd4;

  // Character codes
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;

  // Queue sizes
  localparam int MQ_DEPTH = 4;
  localparam int MQ_AW    = 2;
  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = 2;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_input;
  } qsl_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic       given_back;
    logic       last;
  } qsl_result_t;

  // Item after classification by the front part
  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
    logic       is_open;
    logic       is_digit;
    logic       is_zero;
    logic       is_bslash;
    logic [7:0] esc_val;
  } qsl_class_t;

  typedef struct packed {
    logic [7:0] delim_a;
    logic [7:0] delim_b;
    logic [7:0] char_delim;
    logic       csv_mode;
    logic [8:0] max_len;
  } qsl_cfg_t;

  // Write bundle from the back part into the result queue
  typedef struct packed {
    logic        wr0;
    logic        wr1;
    qsl_result_t d0;
    qsl_result_t d1;
  } qsl_wr_t;

endpackage

// ===== design/qsl_front.sv =====
// Front part: accepts input items and classifies each character.
module qsl_front import qsl_pkg::*; (
  input  logic       push,
  input  logic       full,
  input  qsl_item_t  item,
  input  qsl_cfg_t   cfg,
  output logic       wr,
  output qsl_class_t cls
);

  // Accept when the middle queue has room
  assign wr = push & ~full;

  // Classify the character; translate the simple escapes up front
  always_comb begin
    cls.ch        = item.ch;
    cls.eoi       = item.end_of_input;
    cls.is_open   = (item.ch == cfg.delim_a) || (item.ch == cfg.delim_b);
    cls.is_digit  = (item.ch >= CH_ZERO) && (item.ch <= CH_NINE);
    cls.is_zero   = (item.ch == CH_ZERO);
    cls.is_bslash = (item.ch == CH_BSLASH);
    case (item.ch)
      CH_F:    cls.esc_val = CH_FF;
      CH_N:    cls.esc_val = CH_LF;
      CH_R:    cls.esc_val = CH_CR;
      CH_T:    cls.esc_val = CH_TAB;
      default: cls.esc_val = item.ch;
    endcase
  end

endmodule

// ===== design/qsl_queue.sv =====
// Middle queue holding classified items between front and back parts.
module qsl_queue import qsl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr,
  input  qsl_class_t wdata,
  input  logic       rd,
  output qsl_class_t rdata,
  output logic       full,
  output logic       empty
);

  qsl_class_t     mem [MQ_DEPTH];
  logic [MQ_AW-1:0] wp, rp;
  logic [MQ_AW:0]   count;

  assign full  = (count == (MQ_AW+1)'(MQ_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rp];

  // Store the incoming item
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= wdata;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      count <= count + (MQ_AW+1)'(wr) - (MQ_AW+1)'(rd);
    end
  end

endmodule

// ===== design/qsl_back.sv =====
// Back part: lexer state machine producing up to two results per item.
module qsl_back import qsl_pkg::*; #(
  parameter int MAX_LITERAL_LEN = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  qsl_class_t cls,
  input  logic       q_empty,
  output logic       q_pop,
  input  logic       room,
  input  qsl_cfg_t   cfg,
  output qsl_wr_t    wr
);

  localparam int CNT_W = $clog2(MAX_LITERAL_LEN + 1);
  localparam int LIM_W = (CNT_W > 9) ? CNT_W : 9;

  typedef struct packed {
    phase_t           phase;
    logic [7:0]       open_char;
    logic [7:0]       acc;
    logic [7:0]       first_byte;
    logic [CNT_W-1:0] cnt;
  } st_t;

  typedef struct packed {
    st_t         s;
    qsl_result_t r;
    logic        emit;
    logic        ok;
  } act_t;

  st_t        st, st_next;
  act_t       a0, a1;
  logic       fire;
  logic [LIM_W-1:0] lim;

  // No result, state carried as given
  function automatic act_t act_none(st_t s);
    act_t a;
    a      = '0;
    a.s    = s;
    a.ok   = 1'b1;
    return a;
  endfunction

  // Input ended inside a literal
  function automatic act_t act_unterm(st_t s);
    act_t a;
    a         = '0;
    a.s       = s;
    a.s.phase = PH_IDLE;
    a.r.kind  = KIND_UNTERM;
    a.emit    = 1'b1;
    return a;
  endfunction

  // Append one decoded byte, or stop on the length limit
  function automatic act_t act_push(st_t s, logic [7:0] b, logic gb,
                                    logic [LIM_W-1:0] lm);
    act_t a;
    a      = '0;
    a.s    = s;
    a.emit = 1'b1;
    if (LIM_W'(s.cnt) >= lm) begin
      a.r.kind       = KIND_TOO_LONG;
      a.r.given_back = gb;
      a.s.phase      = PH_IDLE;
    end else begin
      if (s.cnt == '0) a.s.first_byte = b;
      a.s.cnt    = s.cnt + CNT_W'(1);
      a.r.kind   = KIND_BYTE;
      a.r.value  = b;
      a.ok       = 1'b1;
    end
    return a;
  endfunction

  // Close the literal as a string or a character constant
  function automatic act_t act_finish(st_t s, logic gb, logic [7:0] cd);
    act_t a;
    a              = '0;
    a.s            = s;
    a.s.phase      = PH_IDLE;
    a.emit         = 1'b1;
    a.r.given_back = gb;
    if ((cd != 8'd0) && (s.open_char == cd)) begin
      if (s.cnt > CNT_W'(1)) begin
        a.r.kind = KIND_CHAR_LONG;
      end else begin
        a.r.kind  = KIND_CHAR_DONE;
        a.r.value = (s.cnt != '0) ? s.first_byte : 8'd0;
      end
    end else begin
      a.r.kind = KIND_STR_DONE;
    end
    return a;
  endfunction

  // Plain character inside the literal body
  function automatic act_t act_body(st_t s, qsl_class_t c, qsl_cfg_t cf,
                                    logic [LIM_W-1:0] lm);
    act_t a;
    a = act_none(s);
    if (cf.csv_mode) begin
      if (c.ch == s.open_char) a.s.phase = PH_CSVQ;
      else                     a = act_push(s, c.ch, 1'b0, lm);
    end else begin
      if (c.ch == s.open_char) a = act_finish(s, 1'b0, cf.char_delim);
      else if (c.is_bslash)    a.s.phase = PH_ESC;
      else                     a = act_push(s, c.ch, 1'b0, lm);
    end
    return a;
  endfunction

  // Effective length limit
  assign lim = (LIM_W'(cfg.max_len) > LIM_W'(MAX_LITERAL_LEN)) ?
               LIM_W'(MAX_LITERAL_LEN) : LIM_W'(cfg.max_len);

  assign fire  = ~q_empty & room;
  assign q_pop = fire;

  // Work out the actions for the item at the queue head
  always_comb begin
    st_t s1;
    s1 = st;
    a0 = act_none(st);
    a1 = act_none(st);
    case (st.phase)
      PH_BODY: begin
        if (cls.eoi) a0 = act_unterm(st);
        else         a0 = act_body(st, cls, cfg, lim);
        a1 = act_none(a0.s);
      end
      PH_ESC: begin
        if (cls.eoi) begin
          a0 = act_unterm(st);
        end else if (cls.is_zero) begin
          s1.acc   = 8'd0;
          s1.phase = PH_OCT;
          a0 = act_none(s1);
        end else begin
          s1.phase = PH_BODY;
          a0 = act_push(s1, cls.esc_val, 1'b0, lim);
        end
        a1 = act_none(a0.s);
      end
      PH_OCT: begin
        if (!cls.eoi && cls.is_digit) begin
          s1.acc = {st.acc[4:0], 3'b000} + {4'd0, cls.ch[3:0]};
          a0 = act_none(s1);
          a1 = act_none(a0.s);
        end else begin
          s1.phase = PH_BODY;
          a0 = act_push(s1, st.acc, ~cls.eoi, lim);
          if (!a0.ok)       a1 = act_none(a0.s);
          else if (cls.eoi) a1 = act_unterm(a0.s);
          else              a1 = act_body(a0.s, cls, cfg, lim);
        end
      end
      PH_CSVQ: begin
        if (!cls.eoi && (cls.ch == st.open_char)) begin
          s1.phase = PH_BODY;
          a0 = act_push(s1, cls.ch, 1'b0, lim);
        end else begin
          a0 = act_finish(st, ~cls.eoi, cfg.char_delim);
        end
        a1 = act_none(a0.s);
      end
      default: begin
        if (!cls.eoi && cls.is_open) begin
          s1.phase      = PH_BODY;
          s1.open_char  = cls.ch;
          s1.cnt        = '0;
          s1.acc        = 8'd0;
          s1.first_byte = 8'd0;
          a0 = act_none(s1);
        end else begin
          s1.phase = PH_IDLE;
          a0 = act_none(s1);
          a0.emit         = 1'b1;
          a0.r.kind       = KIND_NOT_LIT;
          a0.r.given_back = ~cls.eoi;
        end
        a1 = act_none(a0.s);
      end
    endcase
  end

  // Next state
  always_comb begin
    st_next = st;
    if (fire) st_next = a1.s;
  end

  // Result writes; mark the final result of the item
  always_comb begin
    wr.wr0     = fire & a0.emit;
    wr.wr1     = fire & a0.emit & a1.emit;
    wr.d0      = a0.r;
    wr.d1      = a1.r;
    wr.d0.last = ~a1.emit;
    wr.d1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else begin
      st <= st_next;
    end
  end

  // Length count never passes the build-time limit
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    st.cnt <= CNT_W'(MAX_LITERAL_LEN))
    else $error("byte count beyond limit");

  // End of input always leaves the lexer idle
  a_eoi_idle: assert property (@(posedge clk) disable iff (rst)
    (fire && cls.eoi) |=> (st.phase == PH_IDLE))
    else $error("not idle after end of input");

  // A pending closing character resolves to body or idle
  a_csvq_exit: assert property (@(posedge clk) disable iff (rst)
    (fire && st.phase == PH_CSVQ) |=> (st.phase == PH_IDLE || st.phase == PH_BODY))
    else $error("bad exit from closing-character phase");

endmodule

// ===== design/qsl_res_queue.sv =====
// Result queue taking up to two results per cycle and giving one.
module qsl_res_queue import qsl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  qsl_wr_t     wr,
  input  logic        pop,
  output qsl_result_t result,
  output logic        empty,
  output logic        room
);

  qsl_result_t      mem [RQ_DEPTH];
  logic [RQ_AW-1:0] wp, rp;
  logic [RQ_AW:0]   count;
  logic             rd;

  assign empty  = (count == '0);
  assign rd     = pop & ~empty;
  assign result = mem[rp];
  // Room for two more results
  assign room   = (count <= (RQ_AW+1)'(RQ_DEPTH - 2));

  // Store results
  always_ff @(posedge clk) begin
    if (wr.wr0) mem[wp] <= wr.d0;
    if (wr.wr1) mem[wp + 1'b1] <= wr.d1;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + RQ_AW'(wr.wr0) + RQ_AW'(wr.wr1);
      if (rd) rp <= rp + 1'b1;
      count <= count + (RQ_AW+1)'(wr.wr0) + (RQ_AW+1)'(wr.wr1) - (RQ_AW+1)'(rd);
    end
  end

endmodule

// ===== design/quoted_string_literal_lexer.sv =====
// Top level of the quoted string literal lexer.
//
// Input side is a queue: present one character item with push; it is taken
// on an edge where push is high and full is low. end_of_input marks the end
// of the text and carries no character.
// Result side is a queue: while empty is low the oldest result sits on the
// result port; pop takes it. Each item yields zero, one or two results, the
// final one of an item flagged by last.
// Configuration: write cfg_data to register cfg_index (delim_a, delim_b,
// char_delim, csv_mode, max_len) with cfg_valid; cfg_ready is always high.
// Write only while no item is in flight.
// The middle queue registers each item; the back part then writes its
// results into the result queue once it has room, for pop to take.
// Throughput: one item per cycle while the result queue has room, as the
// back part's lexer step is combinational; a steady run of two-result
// items is paced by the one result per cycle read port of that queue.
// Reset clears both queues, returns the lexer to idle and loads the register
// defaults. When pop is held low the result queue fills, the back part stops,
// the four-entry middle queue fills and full rises.
module quoted_string_literal_lexer import qsl_pkg::*; #(
  parameter int MAX_LITERAL_LEN = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  qsl_item_t   item,
  output logic        empty,
  input  logic        pop,
  output qsl_result_t result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  qsl_cfg_t   cfg;
  qsl_class_t cls_in, cls_head;
  qsl_wr_t    wr;
  logic       mq_wr, mq_rd, mq_empty, rq_room;

  assign cfg_ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delim_a    <= 8'd34;
      cfg.delim_b    <= 8'd39;
      cfg.char_delim <= 8'd39;
      cfg.csv_mode   <= 1'b0;
      cfg.max_len    <= 9'd256;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DELIM_A:    cfg.delim_a    <= cfg_data[7:0];
        CFG_DELIM_B:    cfg.delim_b    <= cfg_data[7:0];
        CFG_CHAR_DELIM: cfg.char_delim <= cfg_data[7:0];
        CFG_CSV_MODE:   cfg.csv_mode   <= cfg_data[0];
        CFG_MAX_LEN:    cfg.max_len    <= cfg_data;
        default: ;
      endcase
    end
  end

  qsl_front u_front (
    .push (push),
    .full (full),
    .item (item),
    .cfg  (cfg),
    .wr   (mq_wr),
    .cls  (cls_in)
  );

  qsl_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (mq_wr),
    .wdata (cls_in),
    .rd    (mq_rd),
    .rdata (cls_head),
    .full  (full),
    .empty (mq_empty)
  );

  qsl_back #(
    .MAX_LITERAL_LEN (MAX_LITERAL_LEN)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cls     (cls_head),
    .q_empty (mq_empty),
    .q_pop   (mq_rd),
    .room    (rq_room),
    .cfg     (cfg),
    .wr      (wr)
  );

  qsl_res_queue u_res_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (wr),
    .pop    (pop),
    .result (result),
    .empty  (empty),
    .room   (rq_room)
  );

endmodule

// ===== bench/qsl_checker.sv =====
// Checker for the quoted string literal lexer: predicts every result and compares it.
module qsl_checker import qsl_pkg::*; #(
  parameter int MAX_LITERAL_LEN = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  qsl_item_t   item,
  input  logic        empty,
  input  logic        pop,
  input  qsl_result_t result,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  output int          mismatches,
  output int          pending,
  output int          items_taken,
  output int          results_taken
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam qsl_cfg_t CFG_AFTER_RESET = '{
    delim_a: 8'd34, delim_b: 8'd39, char_delim: 8'd39, csv_mode: 1'b0, max_len: 9'd256
  };

  // Register copy and lexer state as the block should hold them
  qsl_cfg_t    regs;
  phase_t      lx_phase;
  logic [7:0]  lx_open;
  logic [7:0]  lx_oct;
  logic [7:0]  lx_first;
  logic [8:0]  lx_count;

  qsl_result_t step_res[$];
  qsl_result_t expected_results[$];
  int          fails = 0;
  int          n_items = 0;
  int          n_results = 0;

  function automatic void add_result(input logic [2:0] k, input logic [7:0] v,
                                     input logic gb);
    qsl_result_t r;
    r = '{kind: k, value: v, given_back: gb, last: 1'b0};
    step_res = {step_res, r};
  endfunction

  // Append one decoded byte, or end the literal when the length limit is reached
  function automatic logic store_byte(input logic [7:0] b, input logic gb);
    int limit;
    limit = (regs.max_len > MAX_LITERAL_LEN) ? MAX_LITERAL_LEN : int'(regs.max_len);
    if (int'(lx_count) >= limit) begin
      add_result(KIND_TOO_LONG, 8'h00, gb);
      lx_phase = PH_IDLE;
      return 1'b0;
    end
    if (lx_count == 9'd0) lx_first = b;
    lx_count = lx_count + 9'd1;
    add_result(KIND_BYTE, b, 1'b0);
    return 1'b1;
  endfunction

  // Close the literal as a string or as a character constant
  function automatic void close_literal(input logic gb);
    if (regs.char_delim != 8'h00 && lx_open == regs.char_delim) begin
      if (lx_count > 9'd1) add_result(KIND_CHAR_LONG, 8'h00, gb);
      else add_result(KIND_CHAR_DONE, (lx_count != 9'd0) ? lx_first : 8'h00, gb);
    end else begin
      add_result(KIND_STR_DONE, 8'h00, gb);
    end
    lx_phase = PH_IDLE;
  endfunction

  function automatic void body_char(input logic [7:0] c);
    if (regs.csv_mode) begin
      if (c == lx_open) lx_phase = PH_CSVQ;
      else void'(store_byte(c, 1'b0));
    end else begin
      if (c == lx_open) close_literal(1'b0);
      else if (c == CH_BSLASH) lx_phase = PH_ESC;
      else void'(store_byte(c, 1'b0));
    end
  endfunction

  // Advance the lexer by one item and queue the results it causes
  function automatic void lex_step(input logic [7:0] c_in, input logic eoi);
    logic [7:0] c;
    c = c_in;
    step_res.delete();
    case (lx_phase)
      PH_BODY: begin
        if (eoi) begin
          add_result(KIND_UNTERM, 8'h00, 1'b0);
          lx_phase = PH_IDLE;
        end else begin
          body_char(c);
        end
      end
      PH_ESC: begin
        if (eoi) begin
          add_result(KIND_UNTERM, 8'h00, 1'b0);
          lx_phase = PH_IDLE;
        end else if (c == CH_ZERO) begin
          lx_oct = 8'h00;
          lx_phase = PH_OCT;
        end else begin
          lx_phase = PH_BODY;
          case (c)
            CH_F: c = CH_FF;
            CH_N: c = CH_LF;
            CH_R: c = CH_CR;
            CH_T: c = CH_TAB;
            default: ;
          endcase
          void'(store_byte(c, 1'b0));
        end
      end
      PH_OCT: begin
        if (!eoi && c >= CH_ZERO && c <= CH_NINE) begin
          // digits 8 and 9 are taken as they come, wrapping at 256
          lx_oct = {lx_oct[4:0], 3'b000} + (c - CH_ZERO);
        end else begin
          lx_phase = PH_BODY;
          if (store_byte(lx_oct, !eoi)) begin
            if (eoi) begin
              add_result(KIND_UNTERM, 8'h00, 1'b0);
              lx_phase = PH_IDLE;
            end else begin
              body_char(c);
            end
          end
        end
      end
      PH_CSVQ: begin
        if (!eoi && c == lx_open) begin
          lx_phase = PH_BODY;
          void'(store_byte(c, 1'b0));
        end else begin
          close_literal(!eoi);
        end
      end
      default: begin
        lx_phase = PH_IDLE;
        if (!eoi && (c == regs.delim_a || c == regs.delim_b)) begin
          lx_open  = c;
          lx_count = 9'd0;
          lx_oct   = 8'h00;
          lx_first = 8'h00;
          lx_phase = PH_BODY;
        end else begin
          add_result(KIND_NOT_LIT, 8'h00, !eoi);
        end
      end
    endcase
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
    foreach (step_res[i]) expected_results = {expected_results, step_res[i]};
  endfunction

  // Watch all three channels and compare each popped result with the oldest prediction
  always @(posedge clk) begin
    qsl_result_t want;
    if (rst) begin
      regs     = CFG_AFTER_RESET;
      lx_phase = PH_IDLE;
      lx_open  = 8'h00;
      lx_oct   = 8'h00;
      lx_first = 8'h00;
      lx_count = 9'd0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DELIM_A:    regs.delim_a    = cfg_data[7:0];
          CFG_DELIM_B:    regs.delim_b    = cfg_data[7:0];
          CFG_CHAR_DELIM: regs.char_delim = cfg_data[7:0];
          CFG_CSV_MODE:   regs.csv_mode   = cfg_data[0];
          CFG_MAX_LEN:    regs.max_len    = cfg_data;
          default: ;
        endcase
      end
      if (push && !full) begin
        n_items++;
        lex_step(item.ch, item.end_of_input);
      end
      if (pop && !empty) begin
        n_results++;
        if (expected_results.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: result with no prediction: kind %0d value %h given_back %b last %b",
                     $realtime, result.kind, result.value, result.given_back, result.last);
        end else begin
          want = expected_results.pop_front();
          if (result !== want) begin
            fails++;
            if (fails <= 10)
              $display({"%0t: result mismatch (expected/actual): kind %0d/%0d value %h/%h ",
                        "given_back %b/%b last %b/%b"}, $realtime, want.kind, result.kind,
                       want.value, result.value, want.given_back, result.given_back,
                       want.last, result.last);
          end
        end
      end
    end
    mismatches    <= fails;
    pending       <= expected_results.size();
    items_taken   <= n_items;
    results_taken <= n_results;
  end

endmodule

// ===== bench/quoted_string_literal_lexer_test.sv =====
// Top of the lexer bench: clock, reset, character stimulus, register settings and verdict.
module quoted_string_literal_lexer_test import qsl_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         ITEM_TARGET = 1900;
  localparam logic [2:0] CFG_UNUSED  = 3'd7;
  localparam logic [7:0] CH_DQUOTE   = 8'h22;
  localparam logic [7:0] CH_SQUOTE   = 8'h27;

  typedef enum int {RX_STREAM, RX_COIN, RX_SPARSE, RX_COMB} rx_pattern_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        push      = 1'b0;
  logic        pop       = 1'b0;
  logic        cfg_valid = 1'b0;
  qsl_item_t   item      = '0;
  logic [2:0]  cfg_index = '0;
  logic [8:0]  cfg_data  = '0;
  logic        full;
  logic        empty;
  logic        cfg_ready;
  qsl_result_t result;

  int mismatches;
  int pending;
  int items_taken;
  int results_taken;

  // Register values in force, used only to shape the stimulus
  logic [7:0] c_delim_a;
  logic [7:0] c_delim_b;
  logic [7:0] c_char_delim;
  logic       c_csv_mode;
  logic [8:0] c_max_len;

  int burst_left = 0;
  int items_sent = 0;
  int n_settings = 0;

  quoted_string_literal_lexer #(.MAX_LITERAL_LEN(256)) uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  qsl_checker #(.MAX_LITERAL_LEN(256)) lex_check (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending),
    .items_taken(items_taken), .results_taken(results_taken)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result side on a pattern that is picked again at random
  rx_pattern_t rx_mode  = RX_STREAM;
  int          rx_cycle = 0;
  always @(posedge clk) begin
    if (rx_cycle % 64 == 0) rx_mode = rx_pattern_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_STREAM: pop <= 1'b1;
      RX_COIN:   pop <= 1'($urandom_range(0, 1));
      RX_SPARSE: pop <= ($urandom_range(0, 9) == 0);
      default:   pop <= (rx_cycle % 5 != 0);
    endcase
    rx_cycle++;
  end

  // Present one item, hold it until taken, then idle if the burst is over
  task automatic send_item(input logic [7:0] c, input logic eoi);
    int gap;
    item <= '{ch: c, end_of_input: eoi};
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 12);
    end
  endtask

  // Stop sending and let every item in flight come out
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_setting(input logic [2:0] idx, input logic [8:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] a, input logic [7:0] b,
                                input logic [7:0] cd, input logic csv,
                                input logic [8:0] ml);
    drain();
    write_setting(CFG_DELIM_A, {1'b0, a});
    write_setting(CFG_DELIM_B, {1'b0, b});
    write_setting(CFG_CHAR_DELIM, {1'b0, cd});
    write_setting(CFG_CSV_MODE, {8'h00, csv});
    write_setting(CFG_MAX_LEN, ml);
    cfg_valid <= 1'b0;
    c_delim_a    = a;
    c_delim_b    = b;
    c_char_delim = cd;
    c_csv_mode   = csv;
    c_max_len    = ml;
    n_settings++;
  endtask

  // Pick a setting, leaning on the usual quotes and the length extremes
  task automatic random_settings();
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] cd;
    logic [8:0] ml;
    case ($urandom_range(0, 7))
      0, 1, 2, 3: a = CH_DQUOTE;
      4:          a = 8'h00;
      5:          a = 8'hFF;
      default:    a = 8'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 5))
      0, 1, 2: b = CH_SQUOTE;
      3:       b = a;
      default: b = 8'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 5))
      0, 1, 2: cd = b;
      3:       cd = 8'h00;
      4:       cd = a;
      default: cd = 8'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 9))
      0:       ml = 9'd256;
      1:       ml = 9'd1;
      2:       ml = 9'd0;
      3:       ml = 9'd511;
      4:       ml = 9'd255;
      5:       ml = 9'd300;
      default: ml = 9'($urandom_range(1, 16));
    endcase
    apply_settings(a, b, cd, 1'($urandom_range(0, 1)), ml);
  endtask

  // Any byte that neither closes the literal nor starts an escape
  function automatic logic [7:0] plain_char(input logic [7:0] open_c);
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == open_c || (!c_csv_mode && c == CH_BSLASH)) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [7:0] escape_letter();
    case ($urandom_range(0, 7))
      0:       return CH_F;
      1:       return CH_N;
      2:       return CH_R;
      3:       return CH_T;
      4:       return CH_BSLASH;
      5:       return c_delim_a;
      6:       return c_delim_b;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Send one mostly well-formed literal with random body, sometimes broken
  task automatic send_literal();
    logic [7:0] open_c;
    int n;
    int lim;
    int r;
    if ($urandom_range(0, 4) == 0) begin
      if ($urandom_range(0, 2) == 0) send_item(8'($urandom_range(0, 255)), 1'b1);
      else send_item(8'($urandom_range(0, 255)), 1'b0);
    end
    r = $urandom_range(0, 9);
    if (r < 4) open_c = c_delim_a;
    else if (r < 7) open_c = c_delim_b;
    else if (r < 9 && c_char_delim != 8'h00) open_c = c_char_delim;
    else open_c = 8'($urandom_range(0, 255));
    send_item(open_c, 1'b0);

    lim = (c_max_len > 9'd256) ? 256 : int'(c_max_len);
    if (lim <= 20) n = $urandom_range(0, lim + 3);
    else if ($urandom_range(0, 99) == 0) n = lim + 1;
    else n = $urandom_range(0, 12);
    // character constants mostly hold a single byte
    if (open_c == c_char_delim && $urandom_range(0, 1) == 0) n = $urandom_range(0, 1);

    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 9);
      if (c_csv_mode) begin
        if (r < 2) begin
          send_item(open_c, 1'b0);
          send_item(open_c, 1'b0);
        end else begin
          send_item(plain_char(open_c), 1'b0);
        end
      end else begin
        case (r)
          0, 1, 2, 3, 4, 5: send_item(plain_char(open_c), 1'b0);
          6: begin
            send_item(CH_BSLASH, 1'b0);
            send_item(escape_letter(), 1'b0);
          end
          7: begin
            send_item(CH_BSLASH, 1'b0);
            send_item(CH_ZERO, 1'b0);
            repeat ($urandom_range(0, 3)) send_item(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
          end
          8: begin
            send_item(CH_BSLASH, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b0);
          end
          default: send_item(8'($urandom_range(0, 255)), 1'b0);
        endcase
      end
    end

    // Close normally, end the input, or leave the literal open
    r = $urandom_range(0, 9);
    if (r < 7) begin
      send_item(open_c, 1'b0);
      if (c_csv_mode && r >= 5) send_item(8'($urandom_range(0, 255)), 1'b0);
    end else if (r == 7) begin
      send_item(8'($urandom_range(0, 255)), 1'b1);
    end else if (r == 8) begin
      send_item(open_c, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  initial begin
    int rand_start;
    int phase_end;
    c_delim_a    = CH_DQUOTE;
    c_delim_b    = CH_SQUOTE;
    c_char_delim = CH_SQUOTE;
    c_csv_mode   = 1'b0;
    c_max_len    = 9'd256;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Rejected characters and end of input while idle
    send_item("x", 1'b0);
    send_item(8'hA5, 1'b1);
    // String with extreme bytes, escapes and an octal run ended by a letter
    send_item(CH_DQUOTE, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(CH_BSLASH, 1'b0);
    send_item(CH_N, 1'b0);
    send_item(CH_BSLASH, 1'b0);
    send_item("q", 1'b0);
    send_item(CH_BSLASH, 1'b0);
    send_item(CH_ZERO, 1'b0);
    send_item("1", 1'b0);
    send_item("9", 1'b0);
    send_item("z", 1'b0);
    send_item(CH_DQUOTE, 1'b0);
    // Character constants: empty, one byte, too many bytes
    send_item(CH_SQUOTE, 1'b0);
    send_item(CH_SQUOTE, 1'b0);
    send_item(CH_SQUOTE, 1'b0);
    send_item("k", 1'b0);
    send_item(CH_SQUOTE, 1'b0);
    send_item(CH_SQUOTE, 1'b0);
    send_item("a", 1'b0);
    send_item("b", 1'b0);
    send_item(CH_SQUOTE, 1'b0);
    // Input ending inside an octal run and inside an escape
    send_item(CH_DQUOTE, 1'b0);
    send_item(CH_BSLASH, 1'b0);
    send_item(CH_ZERO, 1'b0);
    send_item("3", 1'b0);
    send_item(8'h00, 1'b1);
    send_item(CH_DQUOTE, 1'b0);
    send_item(CH_BSLASH, 1'b0);
    send_item(8'h00, 1'b1);

    // Length limit of one: octal byte over the limit gives its terminator back
    apply_settings(CH_DQUOTE, CH_SQUOTE, CH_SQUOTE, 1'b0, 9'd1);
    send_item(CH_DQUOTE, 1'b0);
    send_item("a", 1'b0);
    send_item(CH_BSLASH, 1'b0);
    send_item(CH_ZERO, 1'b0);
    send_item("1", 1'b0);
    send_item("x", 1'b0);
    send_item(CH_DQUOTE, 1'b0);
    send_item("a", 1'b0);
    send_item("b", 1'b0);
    // Zero limit rejects every byte
    apply_settings(CH_DQUOTE, CH_SQUOTE, 8'h00, 1'b0, 9'd0);
    send_item(CH_SQUOTE, 1'b0);
    send_item("a", 1'b0);
    // Switch to CSV style with an escape still pending
    apply_settings(CH_DQUOTE, CH_SQUOTE, CH_SQUOTE, 1'b0, 9'd256);
    send_item(CH_DQUOTE, 1'b0);
    send_item(CH_BSLASH, 1'b0);
    apply_settings(CH_DQUOTE, CH_SQUOTE, CH_SQUOTE, 1'b1, 9'd256);
    send_item(CH_N, 1'b0);
    send_item(CH_DQUOTE, 1'b0);
    send_item(CH_DQUOTE, 1'b0);
    send_item(CH_DQUOTE, 1'b0);
    send_item("x", 1'b0);
    send_item(CH_SQUOTE, 1'b0);
    send_item(CH_SQUOTE, 1'b0);
    send_item(8'h00, 1'b1);
    // A write to an unused index leaves the registers alone
    drain();
    write_setting(CFG_UNUSED, 9'($urandom_range(0, 511)));
    cfg_valid <= 1'b0;

    // Random phases, each under a fresh register setting
    rand_start = items_sent;
    while (items_sent - rand_start < ITEM_TARGET) begin
      random_settings();
      phase_end = items_sent + $urandom_range(80, 240);
      while (items_sent < phase_end) send_literal();
    end

    // Let the last results out, then give the verdict
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d characters under %0d register settings; %0d results compared.",
             items_taken, n_settings, results_taken);
    $display("Mismatches %0d, predictions left over %0d.", mismatches, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("quoted_string_literal_lexer test passed");
    end else begin
      $display("quoted_string_literal_lexer test failed");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #(10_000_000);
    $display("Timed out with %0d predictions outstanding.", pending);
    $display("quoted_string_literal_lexer test failed");
    $finish;
  end

endmodule
